/* sv/tlpq_pkg.sv */
// ----------------------------------------------------------------------------
// tlpq_pkg: shared types and codes for the two-level priority queue
// Operation codes, status codes, port field widths and the control bundle
// that steers one queue's row of storage cells.
// ----------------------------------------------------------------------------
package tlpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TASK_WIDTH  = 32;

    // Fixed widths of the stream fields.
    localparam int TASK_W   = 32;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 5;
    localparam int OUT_W    = 48;

    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_PROMOTE = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BOTH_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRIO_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NORM_EMPTY = 3'd4;

    // Per-queue command for one cycle; push and pop never come together.
    typedef struct packed {
        logic push;
        logic pop;
    } chain_ctrl_t;

endpackage

/* sv/tlpq_cell.sv */
// ----------------------------------------------------------------------------
// tlpq_cell: one storage cell of a queue row
// Holds one task word. On a pop it takes its upper neighbor's word, on a
// push it loads the new task when it is the first free cell.
// ----------------------------------------------------------------------------
module tlpq_cell #(
    parameter int WIDTH = tlpq_pkg::DEF_TASK_WIDTH
) (
    input  logic             clk,
    input  logic             shift,
    input  logic             load,
    input  logic [WIDTH-1:0] shift_data,
    input  logic [WIDTH-1:0] load_data,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = shift_data;
        end
        else if (load)
        begin
            data_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

/* sv/tlpq_chain.sv */
// ----------------------------------------------------------------------------
// tlpq_chain: one queue as a row of cells
// Cell 0 is the head. A pop moves every word one cell toward the head; a
// push writes the cell indexed by the occupancy count.
// ----------------------------------------------------------------------------
module tlpq_chain #(
    parameter int DEPTH = tlpq_pkg::DEF_QUEUE_DEPTH,
    parameter int WIDTH = tlpq_pkg::DEF_TASK_WIDTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlpq_pkg::chain_ctrl_t ctrl,
    input  logic [WIDTH-1:0]     push_data,
    output logic [WIDTH-1:0]     head,
    output logic [CNT_W-1:0]     count
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [WIDTH-1:0] cell_q [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [WIDTH-1:0] upper;
            if (gi == DEPTH - 1)
            begin : g_top
                // Nothing above the last cell; its word after a pop is unused.
                assign upper = '0;
            end
            else
            begin : g_mid
                assign upper = cell_q[gi + 1];
            end

            tlpq_cell #(
                .WIDTH(WIDTH)
            ) u_cell (
                .clk       (clk),
                .shift     (ctrl.pop),
                .load      (ctrl.push && (cnt_reg == CNT_W'(gi))),
                .shift_data(upper),
                .load_data (push_data),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.push)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign head  = cell_q[0];
    assign count = cnt_reg;

endmodule

/* sv/two_level_priority_queue_promote.sv */
// ----------------------------------------------------------------------------
// two_level_priority_queue_promote: normal and priority task queues
// Push, pop and promote on two queues, each a row of storage cells, with a
// registered result stream that reports status and both occupancy counts.
// ----------------------------------------------------------------------------
// The block takes one operation per clock cycle and returns its result in the
// cycle after the input transfer, through a single output register; input
// is taken whenever that register is empty or is being emptied in the same
// cycle. Each queue is a row of QUEUE_DEPTH cells whose head sits in cell 0:
// a pop shifts every cell one place toward the head, a push loads only the
// cell at the fill count, and the rows need no clearing pass after reset.
module two_level_priority_queue_promote #(
    parameter int QUEUE_DEPTH = tlpq_pkg::DEF_QUEUE_DEPTH,
    parameter int TASK_WIDTH  = tlpq_pkg::DEF_TASK_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // task_word [31:0]
    input  logic [tlpq_pkg::TASK_W-1:0] s_axis_tdata,
    // func [1:0], urgent [2]
    input  logic [2:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status [2:0], task_out [34:3], normal_used [39:35],
    // priority_used [44:40], zero [47:45]
    output logic [tlpq_pkg::OUT_W-1:0]  m_axis_tdata,
    // from_priority [0]
    output logic                        m_axis_tuser
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                   s_accept;
    tlpq_pkg::func_t        func;
    logic                   urgent;
    logic [TASK_WIDTH-1:0]  task_in;

    tlpq_pkg::chain_ctrl_t  norm_op;
    tlpq_pkg::chain_ctrl_t  prio_op;
    tlpq_pkg::chain_ctrl_t  norm_ctrl;
    tlpq_pkg::chain_ctrl_t  prio_ctrl;
    logic [TASK_WIDTH-1:0]  prio_push_data;
    logic [TASK_WIDTH-1:0]  norm_head;
    logic [TASK_WIDTH-1:0]  prio_head;
    logic [CNT_W-1:0]       norm_cnt;
    logic [CNT_W-1:0]       prio_cnt;
    logic [CNT_W-1:0]       norm_after;
    logic [CNT_W-1:0]       prio_after;
    logic                   norm_full;
    logic                   prio_full;

    logic [tlpq_pkg::STATUS_W-1:0] res_status;
    logic [TASK_WIDTH-1:0]         res_task;
    logic                          res_from_prio;

    logic                          out_valid_reg;
    logic [tlpq_pkg::OUT_W-1:0]    out_data_reg;
    logic [tlpq_pkg::OUT_W-1:0]    out_data_next;
    logic                          out_user_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign func          = tlpq_pkg::func_t'(s_axis_tuser[1:0]);
    assign urgent        = s_axis_tuser[2];
    assign task_in       = TASK_WIDTH'(s_axis_tdata);

    assign norm_full = (norm_cnt == CNT_W'(QUEUE_DEPTH));
    assign prio_full = (prio_cnt == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        norm_op        = '0;
        prio_op        = '0;
        prio_push_data = task_in;
        res_status     = tlpq_pkg::ST_OK;
        res_task       = '0;
        res_from_prio  = 1'b0;
        unique case (func)
            tlpq_pkg::FUNC_PUSH:
            begin
                if (urgent)
                begin
                    if (prio_full)
                        res_status = tlpq_pkg::ST_FULL;
                    else
                        prio_op.push = 1'b1;
                end
                else
                begin
                    if (norm_full)
                        res_status = tlpq_pkg::ST_FULL;
                    else
                        norm_op.push = 1'b1;
                end
            end
            tlpq_pkg::FUNC_POP:
            begin
                priority if (prio_cnt != '0)
                begin
                    prio_op.pop   = 1'b1;
                    res_task      = prio_head;
                    res_from_prio = 1'b1;
                end
                else if (norm_cnt != '0)
                begin
                    norm_op.pop = 1'b1;
                    res_task    = norm_head;
                end
                else
                begin
                    res_status = tlpq_pkg::ST_BOTH_EMPTY;
                end
            end
            tlpq_pkg::FUNC_PROMOTE:
            begin
                // An empty normal queue wins over a full priority queue.
                priority if (norm_cnt == '0)
                begin
                    res_status = tlpq_pkg::ST_NORM_EMPTY;
                end
                else if (prio_full)
                begin
                    res_status = tlpq_pkg::ST_PRIO_FULL;
                end
                else
                begin
                    norm_op.pop    = 1'b1;
                    prio_op.push   = 1'b1;
                    prio_push_data = norm_head;
                    res_task       = norm_head;
                end
            end
            tlpq_pkg::FUNC_NOP:
            begin
                res_status = tlpq_pkg::ST_OK;
            end
        endcase
    end

    assign norm_ctrl = s_accept ? norm_op : '0;
    assign prio_ctrl = s_accept ? prio_op : '0;

    assign norm_after = norm_op.push ? norm_cnt + 1'b1 :
                        norm_op.pop  ? norm_cnt - 1'b1 : norm_cnt;
    assign prio_after = prio_op.push ? prio_cnt + 1'b1 :
                        prio_op.pop  ? prio_cnt - 1'b1 : prio_cnt;

    tlpq_chain #(
        .DEPTH(QUEUE_DEPTH),
        .WIDTH(TASK_WIDTH),
        .CNT_W(CNT_W)
    ) u_normal (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (norm_ctrl),
        .push_data(task_in),
        .head     (norm_head),
        .count    (norm_cnt)
    );

    tlpq_chain #(
        .DEPTH(QUEUE_DEPTH),
        .WIDTH(TASK_WIDTH),
        .CNT_W(CNT_W)
    ) u_priority (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (prio_ctrl),
        .push_data(prio_push_data),
        .head     (prio_head),
        .count    (prio_cnt)
    );

    assign out_data_next = {3'b000,
                            tlpq_pkg::USED_W'(prio_after),
                            tlpq_pkg::USED_W'(norm_after),
                            tlpq_pkg::TASK_W'(res_task),
                            res_status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= res_from_prio;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        norm_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("normal queue count exceeds depth");

    a_prio_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prio_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("priority queue count exceeds depth");

    a_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(norm_ctrl.push && norm_ctrl.pop) && !(prio_ctrl.push && prio_ctrl.pop))
        else $error("queue commanded to push and pop at once");

    a_promote_move: assert property (@(posedge clk) disable iff (!rst_n)
        (norm_ctrl.pop && prio_ctrl.push) |=>
        (prio_cnt == CNT_W'($past(prio_cnt) + 1'b1)) &&
        (norm_cnt == CNT_W'($past(norm_cnt) - 1'b1)))
        else $error("promote did not move one task between queues");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_axis_tvalid)
        else $error("accepted operation produced no result");

endmodule
